@@ rtl/tea_cascade_block_cipher_assert.svh @@
// Assertion macros for the cascade cipher
`ifndef TEA_CASCADE_BLOCK_CIPHER_ASSERT_SVH
`define TEA_CASCADE_BLOCK_CIPHER_ASSERT_SVH
`ifndef SYNTH
`define TCBC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcbc assertion failed");
`define TCBC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcbc assertion failed");
`else
`define TCBC_ASSERT_IMP(label, clk, rst, ante, cons)
`define TCBC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/tcbc_pkg.sv @@
package tcbc_pkg;

   localparam int ROUNDS_DEF = 16;
   localparam logic [31:0] TEA_DELTA = 32'h9E3779B9;

   typedef logic [63:0] word_type;
   typedef logic [7:0][63:0] block_type;
   typedef logic [3:0][63:0] quad_type;

   typedef enum logic [1:0] {
      REG_KEY_ONE   = 2'd0,
      REG_KEY_TWO   = 2'd1,
      REG_KEY_THREE = 2'd2,
      REG_INIT_VEC  = 2'd3
   } reg_index_type;

   typedef enum logic {
      FUNC_ENCRYPT = 1'b0,
      FUNC_DECRYPT = 1'b1
   } func_type;

   typedef struct packed {
      logic        func;
      logic [31:0] block_counter;
      word_type    in_word_0;
      word_type    in_word_1;
      word_type    in_word_2;
      word_type    in_word_3;
      word_type    in_word_4;
      word_type    in_word_5;
      word_type    in_word_6;
      word_type    in_word_7;
   } req_type;

   typedef struct packed {
      word_type out_word_0;
      word_type out_word_1;
      word_type out_word_2;
      word_type out_word_3;
      word_type out_word_4;
      word_type out_word_5;
      word_type out_word_6;
      word_type out_word_7;
   } rsp_type;

   typedef struct packed {
      logic        func;
      logic [31:0] counter;
      block_type   w;
   } pipe_type;

   function automatic logic [31:0] tea_sum(input int i);
      logic [63:0] p;
      p = 64'(TEA_DELTA) * 64'(i);
      return p[31:0];
   endfunction

   function automatic logic [31:0] tea_f(input logic [31:0] v, input logic [31:0] k0,
                                         input logic [31:0] k1, input logic [31:0] s);
      return (v << 4) + (k0 ^ v) + (s ^ (v >> 5)) + k1;
   endfunction

   function automatic block_type whiten(input block_type w, input logic [31:0] counter,
                                        input word_type iv);
      logic [31:0] x;
      block_type   r;
      x = counter + iv[41:10];
      if (x == 32'd0) x = 32'd1;
      r = w;
      for (int j = 0; j < 8; j++) begin
         x = x ^ (x << 17);
         x = x ^ (x >> 13);
         x = x ^ (x << 5);
         if (j % 2 == 0) r[j] = r[j] ^ ({32'd0, x} + iv);
         else r[j] = r[j] ^ ({32'd0, x} - iv);
      end
      return r;
   endfunction

   function automatic quad_type disperse3(input quad_type q);
      quad_type x;
      x = q;
      for (int r = 0; r < 3; r++) begin
         x[0] = x[0] ^ x[1];
         x[1] = x[1] ^ x[2];
         x[2] = x[2] ^ x[3];
         x[3] = x[3] ^ x[0];
      end
      return x;
   endfunction

   function automatic quad_type contract3(input quad_type q);
      quad_type x;
      x = q;
      for (int r = 0; r < 3; r++) begin
         x[3] = x[3] ^ x[0];
         x[2] = x[2] ^ x[3];
         x[1] = x[1] ^ x[2];
         x[0] = x[0] ^ x[1];
      end
      return x;
   endfunction

endpackage

@@ rtl/tea_cascade_block_cipher.sv @@
// Cascaded four-lane TEA cipher over a 64-byte block of eight 64-bit words.
// Request channel (req_valid / req_stall / req_data): func selects encrypt
// or decrypt, block_counter seeds the whitening stream, in_word_0..7 carry
// the block. Response channel (rsp_valid / rsp_stall / rsp_data) returns
// out_word_0..7, one response per request, in request order.
// Config channel (csr_valid / csr_ready / csr_index / csr_data) writes the
// three keys and the init vector; csr_ready is always high. Write only while
// no block is in flight.
// The pipeline is a pre stage, three chains of ROUNDS round cells with a mix
// stage between them, and the response register. Throughput is one block per
// cycle while rsp_stall does not hold the pipeline; each round cell does one
// full TEA round on four lanes.
// When the response is held by rsp_stall the whole pipeline holds and
// req_stall rises. Reset clears all keys to zero and empties the pipeline.
module tea_cascade_block_cipher #(
   parameter int ROUNDS = tcbc_pkg::ROUNDS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tcbc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tcbc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [63:0]       csr_data
);
   import tcbc_pkg::*;
   `include "tea_cascade_block_cipher_assert.svh"

   word_type key_one_ff, key_two_ff, key_three_ff, init_vec_ff;

   logic     advance;
   logic     pre_valid_ff, mix1_valid_ff, mix2_valid_ff, rsp_valid_ff;
   pipe_type pre_data_ff, mix1_data_ff, mix2_data_ff, rsp_data_ff;
   pipe_type pre_data_in, mix1_data_in, mix2_data_in, rsp_data_in;
   logic     p1_valid, p2_valid, p3_valid;
   pipe_type p1_data, p2_data, p3_data, req_pipe;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_one_ff   <= '0;
         key_two_ff   <= '0;
         key_three_ff <= '0;
         init_vec_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_KEY_ONE:   key_one_ff   <= csr_data;
            REG_KEY_TWO:   key_two_ff   <= csr_data;
            REG_KEY_THREE: key_three_ff <= csr_data;
            REG_INIT_VEC:  init_vec_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // hold everything while the response register is full and stalled
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      req_pipe.func    = req_data.func;
      req_pipe.counter = req_data.block_counter;
      req_pipe.w[0] = req_data.in_word_0;
      req_pipe.w[1] = req_data.in_word_1;
      req_pipe.w[2] = req_data.in_word_2;
      req_pipe.w[3] = req_data.in_word_3;
      req_pipe.w[4] = req_data.in_word_4;
      req_pipe.w[5] = req_data.in_word_5;
      req_pipe.w[6] = req_data.in_word_6;
      req_pipe.w[7] = req_data.in_word_7;
   end

   always_comb begin
      pre_data_in = req_pipe;
      if (req_pipe.func == FUNC_ENCRYPT) begin
         pre_data_in.w = whiten(req_pipe.w, req_pipe.counter, init_vec_ff);
      end else begin
         pre_data_in.w[7:4] = contract3(req_pipe.w[7:4]);
      end
   end

   tcbc_tea_pass #(.ROUNDS(ROUNDS), .HI(1'b0), .SWAP(1'b1)) u_pass1 (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(pre_valid_ff), .in_data(pre_data_ff),
      .key_p(key_two_ff), .key_q(key_one_ff),
      .out_valid(p1_valid), .out_data(p1_data)
   );

   always_comb begin
      quad_type lo, hi;
      lo = p1_data.w[3:0];
      hi = p1_data.w[7:4];
      mix1_data_in = p1_data;
      if (p1_data.func == FUNC_ENCRYPT) begin
         lo = disperse3(lo);
         hi[0] = hi[0] ^ lo[3];
         hi[1] = hi[1] - lo[2];
         hi[2] = hi[2] ^ lo[1];
         hi[3] = hi[3] + lo[0];
      end else begin
         lo[0] = lo[0] - hi[3];
         lo[1] = lo[1] ^ hi[2];
         lo[2] = lo[2] + hi[1];
         lo[3] = lo[3] ^ hi[0];
         hi = contract3(hi);
      end
      mix1_data_in.w = {hi, lo};
   end

   tcbc_tea_pass #(.ROUNDS(ROUNDS), .HI(1'b1), .SWAP(1'b0)) u_pass2 (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(mix1_valid_ff), .in_data(mix1_data_ff),
      .key_p(key_two_ff), .key_q(key_three_ff),
      .out_valid(p2_valid), .out_data(p2_data)
   );

   always_comb begin
      quad_type lo, hi;
      lo = p2_data.w[3:0];
      hi = p2_data.w[7:4];
      mix2_data_in = p2_data;
      if (p2_data.func == FUNC_ENCRYPT) begin
         hi = disperse3(hi);
         lo[0] = lo[0] + hi[3];
         lo[1] = lo[1] ^ hi[2];
         lo[2] = lo[2] - hi[1];
         lo[3] = lo[3] ^ hi[0];
      end else begin
         hi[0] = hi[0] ^ lo[3];
         hi[1] = hi[1] + lo[2];
         hi[2] = hi[2] ^ lo[1];
         hi[3] = hi[3] - lo[0];
         lo = contract3(lo);
      end
      mix2_data_in.w = {hi, lo};
   end

   tcbc_tea_pass #(.ROUNDS(ROUNDS), .HI(1'b0), .SWAP(1'b1)) u_pass3 (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(mix2_valid_ff), .in_data(mix2_data_ff),
      .key_p(key_one_ff), .key_q(key_two_ff),
      .out_valid(p3_valid), .out_data(p3_data)
   );

   always_comb begin
      rsp_data_in = p3_data;
      if (p3_data.func == FUNC_ENCRYPT) begin
         rsp_data_in.w[7:4] = disperse3(p3_data.w[7:4]);
      end else begin
         rsp_data_in.w = whiten(p3_data.w, p3_data.counter, init_vec_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff  <= 1'b0;
         mix1_valid_ff <= 1'b0;
         mix2_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         pre_valid_ff  <= req_valid;
         mix1_valid_ff <= p1_valid;
         mix2_valid_ff <= p2_valid;
         rsp_valid_ff  <= p3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pre_data_ff  <= pre_data_in;
         mix1_data_ff <= mix1_data_in;
         mix2_data_ff <= mix2_data_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data.out_word_0 = rsp_data_ff.w[0];
   assign rsp_data.out_word_1 = rsp_data_ff.w[1];
   assign rsp_data.out_word_2 = rsp_data_ff.w[2];
   assign rsp_data.out_word_3 = rsp_data_ff.w[3];
   assign rsp_data.out_word_4 = rsp_data_ff.w[4];
   assign rsp_data.out_word_5 = rsp_data_ff.w[5];
   assign rsp_data.out_word_6 = rsp_data_ff.w[6];
   assign rsp_data.out_word_7 = rsp_data_ff.w[7];

   `TCBC_ASSERT_IMP(a_stall_backs_up, clock, reset, rsp_valid && rsp_stall, req_stall)
   `TCBC_ASSERT_NXT(a_no_phantom_rsp, clock, reset, !p3_valid && advance, !rsp_valid)
   `TCBC_ASSERT_NXT(a_pre_enters, clock, reset, req_valid && !req_stall, pre_valid_ff)
endmodule

@@ rtl/tcbc_round_cell.sv @@
module tcbc_round_cell #(
   parameter int ROUNDS = tcbc_pkg::ROUNDS_DEF,
   parameter int IDX    = 0,
   parameter bit HI     = 1'b0,
   parameter bit SWAP   = 1'b0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  tcbc_pkg::pipe_type in_data,
   input  tcbc_pkg::word_type key_p,
   input  tcbc_pkg::word_type key_q,
   output logic               out_valid,
   output tcbc_pkg::pipe_type out_data
);
   import tcbc_pkg::*;

   localparam int LB = HI ? 4 : 0;
   localparam logic [31:0] S_ENC = tea_sum(IDX + 1);
   localparam logic [31:0] S_DEC = tea_sum(ROUNDS - IDX);

   logic     valid_ff;
   pipe_type data_ff, data_in;
   word_type kp, kq;

   // decrypt walks the key pair in the opposite order for swapped passes
   assign kp = (SWAP && in_data.func == FUNC_DECRYPT) ? key_q : key_p;
   assign kq = (SWAP && in_data.func == FUNC_DECRYPT) ? key_p : key_q;

   always_comb begin
      logic [31:0] y, z;
      data_in = in_data;
      for (int l = 0; l < 4; l++) begin
         y = in_data.w[LB + l][31:0];
         z = in_data.w[LB + l][63:32];
         if (in_data.func == FUNC_ENCRYPT) begin
            y = y + tea_f(z, kp[31:0], kp[63:32], S_ENC);
            z = z + tea_f(y, kq[31:0], kq[63:32], S_ENC);
         end else begin
            z = z - tea_f(y, kq[31:0], kq[63:32], S_DEC);
            y = y - tea_f(z, kp[31:0], kp[63:32], S_DEC);
         end
         data_in.w[LB + l] = {z, y};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

@@ rtl/tcbc_tea_pass.sv @@
module tcbc_tea_pass #(
   parameter int ROUNDS = tcbc_pkg::ROUNDS_DEF,
   parameter bit HI     = 1'b0,
   parameter bit SWAP   = 1'b0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  tcbc_pkg::pipe_type in_data,
   input  tcbc_pkg::word_type key_p,
   input  tcbc_pkg::word_type key_q,
   output logic               out_valid,
   output tcbc_pkg::pipe_type out_data
);
   import tcbc_pkg::*;

   logic     chain_valid [ROUNDS+1];
   pipe_type chain_data  [ROUNDS+1];

   assign chain_valid[0] = in_valid;
   assign chain_data[0]  = in_data;

   for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
      tcbc_round_cell #(
         .ROUNDS(ROUNDS),
         .IDX   (g),
         .HI    (HI),
         .SWAP  (SWAP)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_valid (chain_valid[g]),
         .in_data  (chain_data[g]),
         .key_p    (key_p),
         .key_q    (key_q),
         .out_valid(chain_valid[g+1]),
         .out_data (chain_data[g+1])
      );
   end

   assign out_valid = chain_valid[ROUNDS];
   assign out_data  = chain_data[ROUNDS];
endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import tcbc_pkg::*;

   localparam int LANE_ROUNDS = 16;
   localparam int PIPE_DEPTH  = 3 * LANE_ROUNDS + 4;
   localparam int STALL_LIMIT = 4000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   logic [63:0] key_one_q, key_two_q, key_three_q, init_vec_q;
   rsp_type     block_queue[$];
   int          error_count;
   int          idle_cycles;
   int          rsp_count;
   bit          calm;

   tea_cascade_block_cipher u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   function automatic logic [31:0] round_f(logic [31:0] v, logic [31:0] k0,
                                           logic [31:0] k1, logic [31:0] s);
      return (v << 4) + (k0 ^ v) + (s ^ (v >> 5)) + k1;
   endfunction

   function automatic void tea_lanes(ref logic [63:0] v[4], input logic [63:0] kp,
                                     input logic [63:0] kq, input bit inverse);
      logic [31:0] y, z, s;
      for (int l = 0; l < 4; l++) begin
         y = v[l][31:0];
         z = v[l][63:32];
         for (int i = 1; i <= LANE_ROUNDS; i++) begin
            if (!inverse) begin
               s = 32'h9E3779B9 * i;
               y += round_f(z, kp[31:0], kp[63:32], s);
               z += round_f(y, kq[31:0], kq[63:32], s);
            end else begin
               s = 32'h9E3779B9 * (LANE_ROUNDS + 1 - i);
               z -= round_f(y, kq[31:0], kq[63:32], s);
               y -= round_f(z, kp[31:0], kp[63:32], s);
            end
         end
         v[l] = {z, y};
      end
   endfunction

   function automatic void xor_spread(ref logic [63:0] x[4], input bit inverse);
      for (int r = 0; r < 3; r++) begin
         if (!inverse) begin
            x[0] ^= x[1]; x[1] ^= x[2]; x[2] ^= x[3]; x[3] ^= x[0];
         end else begin
            x[3] ^= x[0]; x[2] ^= x[3]; x[1] ^= x[2]; x[0] ^= x[1];
         end
      end
   endfunction

   function automatic void whiten_block(ref logic [63:0] v[8], input logic [31:0] ctr);
      logic [31:0] x;
      x = ctr + init_vec_q[41:10];
      if (x == 32'd0) x = 32'd1;
      for (int j = 0; j < 8; j++) begin
         x ^= x << 17;
         x ^= x >> 13;
         x ^= x << 5;
         if (j % 2 == 0) v[j] ^= {32'd0, x} + init_vec_q;
         else v[j] ^= {32'd0, x} - init_vec_q;
      end
   endfunction

   function automatic rsp_type cipher_block(req_type rq);
      logic [63:0] lo[4], hi[4], v[8];
      rsp_type     r;
      v = '{rq.in_word_0, rq.in_word_1, rq.in_word_2, rq.in_word_3,
            rq.in_word_4, rq.in_word_5, rq.in_word_6, rq.in_word_7};
      if (func_type'(rq.func) == FUNC_ENCRYPT) begin
         whiten_block(v, rq.block_counter);
         for (int j = 0; j < 4; j++) begin lo[j] = v[j]; hi[j] = v[4 + j]; end
         tea_lanes(lo, key_two_q, key_one_q, 1'b0);
         xor_spread(lo, 1'b0);
         hi[0] ^= lo[3]; hi[1] -= lo[2]; hi[2] ^= lo[1]; hi[3] += lo[0];
         tea_lanes(hi, key_two_q, key_three_q, 1'b0);
         xor_spread(hi, 1'b0);
         lo[0] += hi[3]; lo[1] ^= hi[2]; lo[2] -= hi[1]; lo[3] ^= hi[0];
         tea_lanes(lo, key_one_q, key_two_q, 1'b0);
         xor_spread(hi, 1'b0);
         for (int j = 0; j < 4; j++) begin v[j] = lo[j]; v[4 + j] = hi[j]; end
      end else begin
         for (int j = 0; j < 4; j++) begin lo[j] = v[j]; hi[j] = v[4 + j]; end
         xor_spread(hi, 1'b1);
         tea_lanes(lo, key_one_q, key_two_q, 1'b1);
         lo[0] -= hi[3]; lo[1] ^= hi[2]; lo[2] += hi[1]; lo[3] ^= hi[0];
         xor_spread(hi, 1'b1);
         tea_lanes(hi, key_two_q, key_three_q, 1'b1);
         hi[0] ^= lo[3]; hi[1] += lo[2]; hi[2] ^= lo[1]; hi[3] -= lo[0];
         xor_spread(lo, 1'b1);
         tea_lanes(lo, key_two_q, key_one_q, 1'b1);
         for (int j = 0; j < 4; j++) begin v[j] = lo[j]; v[4 + j] = hi[j]; end
         whiten_block(v, rq.block_counter);
      end
      r = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
      return r;
   endfunction

   function automatic logic [63:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 64'd0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_type rand_block();
      req_type rq;
      rq.func          = 1'($urandom_range(0, 1));
      rq.block_counter = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 32'd0 : '1)
                                                     : $urandom;
      rq.in_word_0 = rand_word(); rq.in_word_1 = rand_word();
      rq.in_word_2 = rand_word(); rq.in_word_3 = rand_word();
      rq.in_word_4 = rand_word(); rq.in_word_5 = rand_word();
      rq.in_word_6 = rand_word(); rq.in_word_7 = rand_word();
      return rq;
   endfunction

   task automatic send_block(req_type rq);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      block_queue.push_back(cipher_block(rq));
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (block_queue.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_KEY_ONE:   key_one_q   = value;
         REG_KEY_TWO:   key_two_q   = value;
         REG_KEY_THREE: key_three_q = value;
         REG_INIT_VEC:  init_vec_q  = value;
         default: ;
      endcase
   endtask

   task automatic load_keys(logic [63:0] k1, logic [63:0] k2, logic [63:0] k3,
                            logic [63:0] iv);
      drain_pipe();
      write_reg(REG_KEY_ONE, k1);
      write_reg(REG_KEY_TWO, k2);
      write_reg(REG_KEY_THREE, k3);
      write_reg(REG_INIT_VEC, iv);
   endtask

   task automatic test_reset_keys();
      req_type rq;
      rq = '0;
      send_block(rq);
      rq.func = FUNC_DECRYPT;
      send_block(rq);
      rq = '1;
      rq.func = FUNC_ENCRYPT;
      send_block(rq);
      rq.func = FUNC_DECRYPT;
      send_block(rq);
   endtask

   task automatic test_directed_edges();
      req_type rq;
      load_keys('1, '1, '1, '1);
      rq = '1; send_block(rq);
      rq.func = FUNC_DECRYPT; send_block(rq);
      rq = '0; send_block(rq);
      // seed that wraps to zero: counter + (iv >> 10) == 0
      load_keys(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 64'h0F1E2D3C4B5A6978,
                64'h0000_0000_0000_0400);
      rq = rand_block();
      rq.block_counter = 32'hFFFF_FFFF;
      rq.func = FUNC_ENCRYPT; send_block(rq);
      rq.func = FUNC_DECRYPT; send_block(rq);
      rq.block_counter = 32'd0;
      send_block(rq);
      for (int i = 0; i < 8; i++) begin
         rq = rand_block();
         send_block(rq);
      end
   endtask

   task automatic test_round_trip();
      req_type rq, back;
      rsp_type ct;
      for (int i = 0; i < 6; i++) begin
         rq = rand_block();
         rq.func = FUNC_ENCRYPT;
         ct = cipher_block(rq);
         send_block(rq);
         back = {FUNC_DECRYPT, rq.block_counter, ct};
         send_block(back);
      end
   endtask

   task automatic test_random_blocks(int n_items);
      for (int i = 0; i < n_items; i++) send_block(rand_block());
   endtask

   // checker: compare each response transfer against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (block_queue.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, rsp_data);
            error_count++;
         end else if (rsp_data !== block_queue[0]) begin
            $display("%0t: mismatch, expected %h, actual %h", $time, block_queue[0],
                     rsp_data);
            error_count++;
            void'(block_queue.pop_front());
         end else begin
            void'(block_queue.pop_front());
         end
      end
   end

   // random back-pressure in bursts
   int stall_left;
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 2);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_index   = REG_KEY_ONE;
      csr_data    = '0;
      key_one_q   = '0;
      key_two_q   = '0;
      key_three_q = '0;
      init_vec_q  = '0;
      error_count = 0;
      rsp_count   = 0;
      calm        = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_keys();
      test_directed_edges();
      test_round_trip();
      load_keys({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom});
      test_random_blocks(600);
      load_keys('0, '1, 64'h8000_0000_0000_0001, 64'hFFFF_FFFF_0000_0000);
      test_random_blocks(500);
      load_keys({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom});
      test_random_blocks(400);
      calm = 1'b1;
      test_random_blocks(300);

      drain_pipe();
      $display("tb_top: %0d blocks checked, encrypt and decrypt under six key sets,", rsp_count);
      $display("tb_top: including round trips, all-zero/all-one data and seed wrap.");
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
